// ----- hw/rtl/dependency_topological_orderer_top_macros.svh -----
// Assertion macros shared by the orderer's port checker.
// Depends on nothing; expects clk and rst_n in the enclosing scope.
`ifndef DEPENDENCY_TOPOLOGICAL_ORDERER_TOP_MACROS_SVH
`define DEPENDENCY_TOPOLOGICAL_ORDERER_TOP_MACROS_SVH

// same-cycle implication
`define DTO_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define DTO_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- hw/rtl/dto_pkg.sv -----
// Shared types and constants of the dependency orderer.
// No dependencies.
`default_nettype none

package dto_pkg;

    localparam int NODE_IDS_DEF = 64;
    localparam int MAX_DEPS_DEF = 8;
    localparam int ID_FW = 6;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_TRACK   = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CYCLE = 2'd1,
        ST_FULL  = 2'd2
    } st_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_GETCNT, S_SCAN_RD, S_SCAN_CMP,
        S_RESP_OK, S_RESP_FULL, S_RESP_CYCLE,
        S_ROOT, S_ROOT_CHK, S_NODE_RD, S_NODE_CNT, S_NODE_LATCH,
        S_STEP, S_DEP, S_TOP_LOAD, S_FINAL
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_CAPTURE, DP_LOOKUP, DP_GETCNT, DP_SCAN_RD, DP_SCAN_NEXT,
        DP_APPEND, DP_CLEAR_GRAPH, DP_RES_START, DP_PASS2, DP_ROOT_RD,
        DP_ROOT_SKIP, DP_PUSH_ROOT, DP_NODE_RD, DP_NODE_CNT, DP_NODE_LATCH,
        DP_DEP_RD, DP_POP, DP_PUSH_DEP, DP_TOP_LOAD
    } dp_op_t;

    typedef enum logic [2:0] {
        LD_NONE, LD_OK, LD_FULL, LD_CYCLE, LD_FINAL
    } ld_t;

    typedef struct packed {
        dp_op_t op;
        ld_t    ld;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic scan_more;
        logic scan_hit;
        logic list_full;
        logic root_more;
        logic root_done;
        logic dep_more;
        logic dep_done;
        logic dep_on_path;
        logic sp_one;
        logic out_free;
        logic pop_wait;
        logic pass2;
    } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dto_controller.sv -----
// Sequencer of the orderer: decodes words, steps the walk, issues datapath commands.
// Depends on dto_pkg.
`default_nettype none

module dto_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dto_pkg::sts_t sts,
    output dto_pkg::cmd_t      cmd
);

    dto_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dto_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = dto_pkg::DP_NOP;
        cmd.ld     = dto_pkg::LD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            dto_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = dto_pkg::DP_CAPTURE;
                    state_next = dto_pkg::S_DISPATCH;
                end
            end
            dto_pkg::S_DISPATCH:
            begin
                case (sts.op)
                    dto_pkg::OP_ADD, dto_pkg::OP_TRACK:
                    begin
                        cmd.op     = dto_pkg::DP_LOOKUP;
                        state_next = dto_pkg::S_GETCNT;
                    end
                    dto_pkg::OP_RESOLVE:
                    begin
                        cmd.op     = dto_pkg::DP_RES_START;
                        state_next = dto_pkg::S_ROOT;
                    end
                    default:
                    begin
                        cmd.op     = dto_pkg::DP_CLEAR_GRAPH;
                        state_next = dto_pkg::S_RESP_OK;
                    end
                endcase
            end
            dto_pkg::S_GETCNT:
            begin
                cmd.op     = dto_pkg::DP_GETCNT;
                state_next = (sts.op == dto_pkg::OP_TRACK) ? dto_pkg::S_RESP_OK
                                                          : dto_pkg::S_SCAN_RD;
            end
            dto_pkg::S_SCAN_RD:
            begin
                if (sts.scan_more)
                begin
                    cmd.op     = dto_pkg::DP_SCAN_RD;
                    state_next = dto_pkg::S_SCAN_CMP;
                end
                else if (sts.list_full)
                begin
                    state_next = dto_pkg::S_RESP_FULL;
                end
                else
                begin
                    cmd.op     = dto_pkg::DP_APPEND;
                    state_next = dto_pkg::S_RESP_OK;
                end
            end
            dto_pkg::S_SCAN_CMP:
            begin
                if (sts.scan_hit)
                begin
                    state_next = dto_pkg::S_RESP_OK;
                end
                else
                begin
                    cmd.op     = dto_pkg::DP_SCAN_NEXT;
                    state_next = dto_pkg::S_SCAN_RD;
                end
            end
            dto_pkg::S_RESP_OK:
            begin
                if (sts.out_free)
                begin
                    cmd.ld     = dto_pkg::LD_OK;
                    state_next = dto_pkg::S_IDLE;
                end
            end
            dto_pkg::S_RESP_FULL:
            begin
                if (sts.out_free)
                begin
                    cmd.ld     = dto_pkg::LD_FULL;
                    state_next = dto_pkg::S_IDLE;
                end
            end
            dto_pkg::S_RESP_CYCLE:
            begin
                if (sts.out_free)
                begin
                    cmd.ld     = dto_pkg::LD_CYCLE;
                    state_next = dto_pkg::S_IDLE;
                end
            end
            dto_pkg::S_ROOT:
            begin
                if (sts.root_more)
                begin
                    cmd.op     = dto_pkg::DP_ROOT_RD;
                    state_next = dto_pkg::S_ROOT_CHK;
                end
                else if (!sts.pass2)
                begin
                    // first pass only checks for cycles; second pass emits
                    cmd.op     = dto_pkg::DP_PASS2;
                end
                else
                begin
                    state_next = dto_pkg::S_FINAL;
                end
            end
            dto_pkg::S_ROOT_CHK:
            begin
                if (sts.root_done)
                begin
                    cmd.op     = dto_pkg::DP_ROOT_SKIP;
                    state_next = dto_pkg::S_ROOT;
                end
                else
                begin
                    cmd.op     = dto_pkg::DP_PUSH_ROOT;
                    state_next = dto_pkg::S_NODE_RD;
                end
            end
            dto_pkg::S_NODE_RD:
            begin
                cmd.op     = dto_pkg::DP_NODE_RD;
                state_next = dto_pkg::S_NODE_CNT;
            end
            dto_pkg::S_NODE_CNT:
            begin
                cmd.op     = dto_pkg::DP_NODE_CNT;
                state_next = dto_pkg::S_NODE_LATCH;
            end
            dto_pkg::S_NODE_LATCH:
            begin
                cmd.op     = dto_pkg::DP_NODE_LATCH;
                state_next = dto_pkg::S_STEP;
            end
            dto_pkg::S_STEP:
            begin
                if (sts.dep_more)
                begin
                    cmd.op     = dto_pkg::DP_DEP_RD;
                    state_next = dto_pkg::S_DEP;
                end
                else if (!sts.pop_wait)
                begin
                    cmd.op     = dto_pkg::DP_POP;
                    state_next = sts.sp_one ? dto_pkg::S_ROOT : dto_pkg::S_TOP_LOAD;
                end
            end
            dto_pkg::S_DEP:
            begin
                if (sts.dep_done)
                begin
                    state_next = dto_pkg::S_STEP;
                end
                else if (sts.dep_on_path)
                begin
                    state_next = dto_pkg::S_RESP_CYCLE;
                end
                else
                begin
                    cmd.op     = dto_pkg::DP_PUSH_DEP;
                    state_next = dto_pkg::S_NODE_RD;
                end
            end
            dto_pkg::S_TOP_LOAD:
            begin
                cmd.op     = dto_pkg::DP_TOP_LOAD;
                state_next = dto_pkg::S_NODE_RD;
            end
            dto_pkg::S_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.ld     = dto_pkg::LD_FINAL;
                    state_next = dto_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dto_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dto_datapath.sv -----
// Graph storage, walk stack, marks and output register of the orderer.
// Depends on dto_pkg; driven by dto_controller commands.
`default_nettype none

module dto_datapath #(
    parameter int NODE_IDS = dto_pkg::NODE_IDS_DEF,
    parameter int MAX_DEPS = dto_pkg::MAX_DEPS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dto_pkg::cmd_t             cmd,
    output dto_pkg::sts_t                  sts,
    input  wire logic [1:0]                operation,
    input  wire logic [dto_pkg::ID_FW-1:0] node,
    input  wire logic [dto_pkg::ID_FW-1:0] dependency,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     status,
    output logic [dto_pkg::ID_FW-1:0]      ordered_node,
    output logic                           node_valid,
    output logic [dto_pkg::ID_FW-1:0]      cycle_from,
    output logic [dto_pkg::ID_FW-1:0]      cycle_to,
    output logic                           last
);

    localparam int FW = dto_pkg::ID_FW;
    localparam int IW = $clog2(NODE_IDS);
    localparam int TW = $clog2(NODE_IDS + 1);
    localparam int CW = $clog2(MAX_DEPS + 1);
    localparam int AW = (NODE_IDS * MAX_DEPS > 2) ? $clog2(NODE_IDS * MAX_DEPS) : 1;
    localparam int KW = IW + CW;

    // ids are taken modulo NODE_IDS; a constant table over the field range
    function automatic logic [IW-1:0] id_reduce(logic [FW-1:0] v);
        logic [IW-1:0] r;
        r = '0;
        for (int j = 0; j < (1 << FW); j++)
        begin
            if (v == FW'(j))
            begin
                r = IW'(j % NODE_IDS);
            end
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] dep_addr(logic [IW-1:0] e, logic [CW-1:0] k);
        return AW'(AW'(e) * AW'(MAX_DEPS)) + AW'(k);
    endfunction

    // memories
    logic [IW-1:0] ent_mem  [NODE_IDS];
    logic [CW-1:0] dtot_mem [NODE_IDS];
    logic [IW-1:0] map_mem  [NODE_IDS];
    logic [IW-1:0] dep_mem  [NODE_IDS * MAX_DEPS];
    logic [KW-1:0] stk_mem  [NODE_IDS];

    logic [IW-1:0] ent_rd_reg, map_rd_reg, dep_rd_reg;
    logic [CW-1:0] dtot_rd_reg;
    logic [KW-1:0] stk_rd_reg;

    // control state
    logic [TW-1:0]       total_reg, root_i_reg, sp_reg;
    logic [NODE_IDS-1:0] mapped_reg, resolved_reg, path_reg;
    logic                pass2_reg, held_valid_reg, out_valid_reg;

    // payload
    dto_pkg::op_t  op_reg;
    logic [IW-1:0] n_reg, d_reg, e_reg, top_n_reg, top_e_reg, held_reg;
    logic [CW-1:0] scan_i_reg, top_k_reg, top_cnt_reg;
    logic          new_reg, top_mapped_reg;
    logic [1:0]    st_reg;
    logic [IW-1:0] onode_reg, from_reg, to_reg;
    logic          nvalid_reg, last_reg;

    logic          out_free, create, do_pop, out_load;
    logic [IW-1:0] e_cur;
    logic [TW-1:0] sp_m1, sp_m2;

    assign out_free = !out_valid_reg || out_ready;
    assign create   = (cmd.op == dto_pkg::DP_LOOKUP) && !mapped_reg[n_reg];
    assign do_pop   = (cmd.op == dto_pkg::DP_POP);
    assign e_cur    = new_reg ? e_reg : map_rd_reg;
    assign sp_m1    = sp_reg - TW'(1);
    assign sp_m2    = sp_reg - TW'(2);
    assign out_load = (cmd.ld != dto_pkg::LD_NONE) || (do_pop && pass2_reg && held_valid_reg);

    always_comb
    begin
        sts.op          = op_reg;
        sts.scan_more   = scan_i_reg < dtot_rd_reg;
        sts.scan_hit    = dep_rd_reg == d_reg;
        sts.list_full   = dtot_rd_reg >= CW'(MAX_DEPS);
        sts.root_more   = root_i_reg < total_reg;
        sts.root_done   = resolved_reg[ent_rd_reg];
        sts.dep_more    = top_k_reg < top_cnt_reg;
        sts.dep_done    = resolved_reg[dep_rd_reg];
        sts.dep_on_path = path_reg[dep_rd_reg];
        sts.sp_one      = sp_reg == TW'(1);
        sts.out_free    = out_free;
        sts.pop_wait    = pass2_reg && held_valid_reg && !out_free;
        sts.pass2       = pass2_reg;
    end

    // entry node table
    always_ff @(posedge clk)
    begin
        if (create)
        begin
            ent_mem[total_reg[IW-1:0]] <= n_reg;
        end
        if (cmd.op == dto_pkg::DP_ROOT_RD)
        begin
            ent_rd_reg <= ent_mem[root_i_reg[IW-1:0]];
        end
    end

    // node to entry map
    always_ff @(posedge clk)
    begin
        if (create)
        begin
            map_mem[n_reg] <= total_reg[IW-1:0];
        end
        if (cmd.op == dto_pkg::DP_LOOKUP)
        begin
            map_rd_reg <= map_mem[n_reg];
        end
        else if (cmd.op == dto_pkg::DP_NODE_RD)
        begin
            map_rd_reg <= map_mem[top_n_reg];
        end
    end

    // dependency counts
    always_ff @(posedge clk)
    begin
        if (create)
        begin
            dtot_mem[total_reg[IW-1:0]] <= '0;
        end
        else if (cmd.op == dto_pkg::DP_APPEND)
        begin
            dtot_mem[e_reg] <= dtot_rd_reg + CW'(1);
        end
        if (cmd.op == dto_pkg::DP_GETCNT)
        begin
            dtot_rd_reg <= dtot_mem[e_cur];
        end
        else if (cmd.op == dto_pkg::DP_NODE_CNT)
        begin
            dtot_rd_reg <= dtot_mem[map_rd_reg];
        end
    end

    // dependency lists
    always_ff @(posedge clk)
    begin
        if (cmd.op == dto_pkg::DP_APPEND)
        begin
            dep_mem[dep_addr(e_reg, dtot_rd_reg)] <= d_reg;
        end
        if (cmd.op == dto_pkg::DP_SCAN_RD)
        begin
            dep_rd_reg <= dep_mem[dep_addr(e_reg, scan_i_reg)];
        end
        else if (cmd.op == dto_pkg::DP_DEP_RD)
        begin
            dep_rd_reg <= dep_mem[dep_addr(top_e_reg, top_k_reg)];
        end
    end

    // walk stack; the top lives in top_n/top_k
    always_ff @(posedge clk)
    begin
        if (cmd.op == dto_pkg::DP_PUSH_DEP)
        begin
            stk_mem[sp_m1[IW-1:0]] <= {top_n_reg, top_k_reg};
        end
        if (do_pop && !sts.sp_one)
        begin
            stk_rd_reg <= stk_mem[sp_m2[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            root_i_reg     <= '0;
            sp_reg         <= '0;
            mapped_reg     <= '0;
            resolved_reg   <= '0;
            path_reg       <= '0;
            pass2_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                dto_pkg::DP_LOOKUP:
                begin
                    if (create)
                    begin
                        mapped_reg[n_reg] <= 1'b1;
                        total_reg         <= total_reg + TW'(1);
                    end
                end
                dto_pkg::DP_CLEAR_GRAPH:
                begin
                    total_reg  <= '0;
                    mapped_reg <= '0;
                end
                dto_pkg::DP_RES_START:
                begin
                    resolved_reg   <= '0;
                    path_reg       <= '0;
                    root_i_reg     <= '0;
                    sp_reg         <= '0;
                    pass2_reg      <= 1'b0;
                    held_valid_reg <= 1'b0;
                end
                dto_pkg::DP_PASS2:
                begin
                    resolved_reg <= '0;
                    path_reg     <= '0;
                    root_i_reg   <= '0;
                    pass2_reg    <= 1'b1;
                end
                dto_pkg::DP_ROOT_SKIP:
                begin
                    root_i_reg <= root_i_reg + TW'(1);
                end
                dto_pkg::DP_PUSH_ROOT:
                begin
                    path_reg[ent_rd_reg] <= 1'b1;
                    sp_reg               <= TW'(1);
                end
                dto_pkg::DP_PUSH_DEP:
                begin
                    path_reg[dep_rd_reg] <= 1'b1;
                    sp_reg               <= sp_reg + TW'(1);
                end
                dto_pkg::DP_POP:
                begin
                    path_reg[top_n_reg]     <= 1'b0;
                    resolved_reg[top_n_reg] <= 1'b1;
                    sp_reg                  <= sp_m1;
                    if (sts.sp_one)
                    begin
                        root_i_reg <= root_i_reg + TW'(1);
                    end
                    if (pass2_reg)
                    begin
                        held_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            dto_pkg::DP_CAPTURE:
            begin
                op_reg <= dto_pkg::op_t'(operation);
                n_reg  <= id_reduce(node);
                d_reg  <= id_reduce(dependency);
            end
            dto_pkg::DP_LOOKUP:
            begin
                e_reg   <= total_reg[IW-1:0];
                new_reg <= create;
            end
            dto_pkg::DP_GETCNT:
            begin
                e_reg      <= e_cur;
                scan_i_reg <= '0;
            end
            dto_pkg::DP_SCAN_NEXT:
            begin
                scan_i_reg <= scan_i_reg + CW'(1);
            end
            dto_pkg::DP_PUSH_ROOT:
            begin
                top_n_reg <= ent_rd_reg;
                top_k_reg <= '0;
            end
            dto_pkg::DP_NODE_RD:
            begin
                top_mapped_reg <= mapped_reg[top_n_reg];
            end
            dto_pkg::DP_NODE_CNT:
            begin
                top_e_reg <= map_rd_reg;
            end
            dto_pkg::DP_NODE_LATCH:
            begin
                top_cnt_reg <= top_mapped_reg ? dtot_rd_reg : '0;
            end
            dto_pkg::DP_DEP_RD:
            begin
                top_k_reg <= top_k_reg + CW'(1);
            end
            dto_pkg::DP_PUSH_DEP:
            begin
                top_n_reg <= dep_rd_reg;
                top_k_reg <= '0;
            end
            dto_pkg::DP_POP:
            begin
                held_reg <= top_n_reg;
            end
            dto_pkg::DP_TOP_LOAD:
            begin
                top_n_reg <= stk_rd_reg[KW-1:CW];
                top_k_reg <= stk_rd_reg[CW-1:0];
            end
            default:
            begin
            end
        endcase

        // output word
        if (do_pop && pass2_reg && held_valid_reg)
        begin
            st_reg     <= dto_pkg::ST_OK;
            onode_reg  <= held_reg;
            nvalid_reg <= 1'b1;
            from_reg   <= '0;
            to_reg     <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.ld)
                dto_pkg::LD_OK, dto_pkg::LD_FULL:
                begin
                    st_reg     <= (cmd.ld == dto_pkg::LD_FULL) ? dto_pkg::ST_FULL
                                                               : dto_pkg::ST_OK;
                    onode_reg  <= '0;
                    nvalid_reg <= 1'b0;
                    from_reg   <= '0;
                    to_reg     <= '0;
                    last_reg   <= 1'b1;
                end
                dto_pkg::LD_CYCLE:
                begin
                    st_reg     <= dto_pkg::ST_CYCLE;
                    onode_reg  <= '0;
                    nvalid_reg <= 1'b0;
                    from_reg   <= top_n_reg;
                    to_reg     <= dep_rd_reg;
                    last_reg   <= 1'b1;
                end
                dto_pkg::LD_FINAL:
                begin
                    st_reg     <= dto_pkg::ST_OK;
                    onode_reg  <= held_valid_reg ? held_reg : '0;
                    nvalid_reg <= held_valid_reg;
                    from_reg   <= '0;
                    to_reg     <= '0;
                    last_reg   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = st_reg;
    assign ordered_node = FW'(onode_reg);
    assign node_valid   = nvalid_reg;
    assign cycle_from   = FW'(from_reg);
    assign cycle_to     = FW'(to_reg);
    assign last         = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dependency_topological_orderer_top.sv -----
// Dependency orderer: graph store with depth-first post-order resolve.
// Usage: words in on in_valid/in_ready (operation, node, dependency); result words
// out on out_valid/out_ready, last marks the final word of each input word.
// Add edge, track and clear each give one word.
// Resolve: two passes over the graph (cycle check, then emit). Each visited node
// costs its reads plus the stack reload and parent re-read, with the single-port
// tables read in series (map, count, dependency list, stack).
// Emits one word per entry-reachable node, or one cycle word, or one empty word.
// Input is taken only while the sequencer is idle; one word at a time.
// Result words sit in an output register; a stalled receiver holds the
// sequencer at its next emit, so nothing is lost.
// Reset empties the graph; table contents are not cleared and need no sweep.
`default_nettype none

module dependency_topological_orderer_top #(
    parameter int NODE_IDS = dto_pkg::NODE_IDS_DEF,
    parameter int MAX_DEPS = dto_pkg::MAX_DEPS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                operation,
    input  wire logic [dto_pkg::ID_FW-1:0] node,
    input  wire logic [dto_pkg::ID_FW-1:0] dependency,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     status,
    output logic [dto_pkg::ID_FW-1:0]      ordered_node,
    output logic                           node_valid,
    output logic [dto_pkg::ID_FW-1:0]      cycle_from,
    output logic [dto_pkg::ID_FW-1:0]      cycle_to,
    output logic                           last
);

    dto_pkg::cmd_t cmd;
    dto_pkg::sts_t sts;

    dto_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dto_datapath #(
        .NODE_IDS (NODE_IDS),
        .MAX_DEPS (MAX_DEPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .node         (node),
        .dependency   (dependency),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .ordered_node (ordered_node),
        .node_valid   (node_valid),
        .cycle_from   (cycle_from),
        .cycle_to     (cycle_to),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dto_checker.sv -----
// Port-level checks of the orderer's result words, bound to the top level.
// Depends on dto_pkg and dependency_topological_orderer_top_macros.svh.
`default_nettype none
`include "dependency_topological_orderer_top_macros.svh"

module dto_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] operation,
    input wire logic [5:0] node,
    input wire logic [5:0] dependency,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] status,
    input wire logic [5:0] ordered_node,
    input wire logic       node_valid,
    input wire logic [5:0] cycle_from,
    input wire logic [5:0] cycle_to,
    input wire logic       last
);

    `DTO_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(operation) && $stable(node) && $stable(dependency), "input word changed while waiting")
    `DTO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ordered_node) && $stable(status) && $stable(last), "result word changed while stalled")
    `DTO_ASSERT_NOW(a_cycle_alone, out_valid && status == dto_pkg::ST_CYCLE, last && !node_valid, "cycle word not alone")
    `DTO_ASSERT_NOW(a_node_ok, out_valid && node_valid, status == dto_pkg::ST_OK && cycle_from == 6'd0 && cycle_to == 6'd0, "order word with bad status")
    `DTO_ASSERT_NOW(a_mid_is_node, out_valid && !last, node_valid, "non-final word carries no node")

endmodule

bind dependency_topological_orderer_top dto_checker u_dto_checker (.*);

`default_nettype wire
